@@ design/mtee_pkg.sv @@
`timescale 1ns / 1ps

package mtee_pkg;

	// Track store depth; track fields are four bits wide
	localparam int TRACK_COUNT = 16;
	localparam int TRACK_W     = 4;

	// Event kinds
	typedef enum logic [1:0] {
		OP_NOTE_ON  = 2'd0,
		OP_NOTE_OFF = 2'd1,
		OP_CTRL     = 2'd2,
		OP_BEND     = 2'd3
	} op_t;

	// Channel message status bases
	localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
	localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
	localparam logic [7:0] STATUS_CTRL     = 8'hB0;
	localparam logic [7:0] STATUS_BEND     = 8'hE0;
	localparam logic [6:0] SEVEN_BITS      = 7'h7F;

	// Register byte addresses (bit 3 selects the register)
	localparam logic ADDR_MASK    = 1'b0;
	localparam logic ADDR_CHANNEL = 1'b1;

	// One encoded event handed from the tick stage to the byte serializer
	typedef struct packed {
		logic [31:0]        delta;
		logic [2:0]         ngrp;
		logic               msg_on;
		logic [7:0]         status;
		logic [6:0]         data_one;
		logic [6:0]         second;
		logic [TRACK_W-1:0] track;
	} evt_t;

endpackage

@@ design/mtee_tick_mem.sv @@
`timescale 1ns / 1ps

module mtee_tick_mem import mtee_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [TRACK_W-1:0] rd_addr,
	output logic [31:0]        rd_data,
	output logic               rd_valid,
	input  logic               wr_en,
	input  logic [TRACK_W-1:0] wr_addr,
	input  logic [31:0]        wr_data
);

	logic [31:0]            mem [TRACK_COUNT];
	logic [TRACK_COUNT-1:0] valid_q;
	logic [31:0]            rd_data_q;
	logic                   rd_valid_q;

	// Write the new tick, registered read of the old one
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Mark written entries; an unwritten entry reads with rd_valid low
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;

endmodule

@@ design/mtee_serializer.sv @@
`timescale 1ns / 1ps

module mtee_serializer import mtee_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  evt_t               evt,
	output logic               busy,
	output logic               done,
	output logic [7:0]         out_byte,
	output logic [TRACK_W-1:0] out_track,
	output logic               out_last,
	output logic               out_valid,
	input  logic               out_ready
);

	evt_t               evt_s2;
	logic               valid_s2;
	logic [2:0]         idx_q;
	logic [3:0]         total;
	logic               emit;
	logic               last;
	logic [2:0]         grp;
	logic [2:0]         msg_k;
	logic [6:0]         grp_bits;
	logic [7:0]         cur_byte;
	logic [7:0]         byte_q;
	logic [TRACK_W-1:0] track_q;
	logic               last_q;
	logic               ovalid_q;

	// Byte count and position within the event
	always_comb begin
		total = {1'b0, evt_s2.ngrp} + (evt_s2.msg_on ? 4'd3 : 4'd0);
		emit  = valid_s2 && (!ovalid_q || out_ready);
		last  = ({1'b0, idx_q} == (total - 4'd1));
		grp   = evt_s2.ngrp - 3'd1 - idx_q;
		msg_k = idx_q - evt_s2.ngrp;
	end

	// Pick the delta group or the message byte for this position
	always_comb begin
		unique case (grp)
			3'd0:    grp_bits = evt_s2.delta[6:0];
			3'd1:    grp_bits = evt_s2.delta[13:7];
			3'd2:    grp_bits = evt_s2.delta[20:14];
			3'd3:    grp_bits = evt_s2.delta[27:21];
			3'd4:    grp_bits = {3'b000, evt_s2.delta[31:28]};
			default: grp_bits = '0;
		endcase
		if (idx_q < evt_s2.ngrp) begin
			cur_byte = {(grp != 3'd0), grp_bits & SEVEN_BITS};
		end else begin
			unique case (msg_k)
				3'd0:    cur_byte = evt_s2.status;
				3'd1:    cur_byte = {1'b0, evt_s2.data_one};
				3'd2:    cur_byte = {1'b0, evt_s2.second};
				default: cur_byte = '0;
			endcase
		end
	end

	// Hold the event and step through its bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (emit) begin
			if (last) begin
				valid_s2 <= 1'b0;
				idx_q    <= '0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			evt_s2 <= evt;
		end
	end

	// Output register decouples the receiver stall from the serializer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q  <= cur_byte;
			track_q <= evt_s2.track;
			last_q  <= last;
		end
	end

	assign busy      = valid_s2;
	assign done      = emit && last;
	assign out_byte  = byte_q;
	assign out_track = track_q;
	assign out_last  = last_q;
	assign out_valid = ovalid_q;

endmodule

@@ design/midi_track_event_encoder.sv @@
`timescale 1ns / 1ps

// MIDI track event encoder.
// Input stream (s_axis): one musical event per request. Events for tracks
// whose bit in the active-track mask is clear are taken and dropped.
// Output stream (m_axis): the encoded bytes of each enabled event, first the
// tick delta as a variable-length quantity (1 to 5 bytes), then the three
// channel message bytes unless the event is a note without a number.
// m_axis_tlast marks the final byte of each event.
// The first byte of an event passes the tick stage, the serializer and the
// output register. Throughput: one byte per cycle while m_axis_tready is
// high, 1 to 8 bytes per event; the next event is read from the tick memory
// while the current one is serialized, so bytes of successive events follow
// without gaps. The single byte-wide output register sets that rate.
// Per-track previous ticks live in a 16-entry memory with a registered read;
// back-to-back events on the same track are forwarded around it.
// Reset clears the mask, the channel table and all previous ticks (valid
// bits, no clearing pass). When the receiver stalls, the output byte holds,
// one event waits in the serializer and one in the tick stage, after which
// s_axis_tready drops.
// Configuration over APB: mask at address 0x0, channel table at 0x8.
module midi_track_event_encoder import mtee_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// Event input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // event_tick[31:0], track_index[35:32],
	                                   // data_one[42:36], data_two[49:43], zero
	input  logic [2:0]  s_axis_tuser,  // operation[1:0], note_present[2]
	// Byte output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // out_byte[7:0], out_track[11:8], zero
	output logic        m_axis_tlast   // last_of_event
);

	logic [15:0]        mask_q;
	logic [63:0]        chan_q;
	logic               cfg_wr;

	logic [31:0]        in_tick;
	logic [TRACK_W-1:0] in_track;
	logic [6:0]         in_d1;
	logic [6:0]         in_d2;
	op_t                in_op;
	logic               in_present;
	logic               in_en;
	logic               accept;

	logic               valid_s1;
	op_t                op_s1;
	logic [31:0]        tick_s1;
	logic [TRACK_W-1:0] track_s1;
	logic               present_s1;
	logic [6:0]         d1_s1;
	logic [6:0]         d2_s1;
	logic               fwd_s1;
	logic [31:0]        fwd_tick_s1;
	logic               adv_s1;

	logic [31:0]        rd_data;
	logic               rd_valid;
	logic [31:0]        prev_tick;
	logic [3:0]         chan;
	evt_t               evt;

	logic               ser_busy;
	logic               ser_done;
	logic [7:0]         out_byte;
	logic [TRACK_W-1:0] out_track;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			chan_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3])
				ADDR_MASK:    mask_q <= pwdata[15:0];
				ADDR_CHANNEL: chan_q <= pwdata;
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			ADDR_MASK:    prdata = {48'd0, mask_q};
			ADDR_CHANNEL: prdata = chan_q;
			default:      prdata = '0;
		endcase
	end

	// Unpack the request and check the track enable
	always_comb begin
		in_tick    = s_axis_tdata[31:0];
		in_track   = s_axis_tdata[35:32];
		in_d1      = s_axis_tdata[42:36];
		in_d2      = s_axis_tdata[49:43];
		in_op      = op_t'(s_axis_tuser[1:0]);
		in_present = s_axis_tuser[2];
		in_en      = ({1'b0, in_track} < 5'(TRACK_COUNT)) && mask_q[in_track];
	end

	assign adv_s1        = valid_s1 && (!ser_busy || ser_done);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Tick stage: take enabled events, drop the rest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= in_en;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the request; forward a same-track write that lands with this read
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= in_op;
			tick_s1     <= in_tick;
			track_s1    <= in_track;
			present_s1  <= in_present;
			d1_s1       <= in_d1;
			d2_s1       <= in_d2;
			fwd_s1      <= adv_s1 && (track_s1 == in_track);
			fwd_tick_s1 <= tick_s1;
		end
	end

	mtee_tick_mem u_tick_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (in_track),
		.rd_data  (rd_data),
		.rd_valid (rd_valid),
		.wr_en    (adv_s1),
		.wr_addr  (track_s1),
		.wr_data  (tick_s1)
	);

	// Delta, group count and channel message
	always_comb begin
		if (fwd_s1) begin
			prev_tick = fwd_tick_s1;
		end else if (rd_valid) begin
			prev_tick = rd_data;
		end else begin
			prev_tick = '0;
		end
		chan      = chan_q[4*track_s1 +: 4];
		evt.delta = tick_s1 - prev_tick;
		evt.track = track_s1;
		evt.data_one = d1_s1;
		priority if (evt.delta[31:28] != '0) begin
			evt.ngrp = 3'd5;
		end else if (evt.delta[27:21] != '0) begin
			evt.ngrp = 3'd4;
		end else if (evt.delta[20:14] != '0) begin
			evt.ngrp = 3'd3;
		end else if (evt.delta[13:7] != '0) begin
			evt.ngrp = 3'd2;
		end else begin
			evt.ngrp = 3'd1;
		end
		unique case (op_s1)
			OP_NOTE_ON: begin
				evt.status = STATUS_NOTE_ON | {4'd0, chan};
				evt.second = d2_s1;
				evt.msg_on = present_s1;
			end
			OP_NOTE_OFF: begin
				evt.status = STATUS_NOTE_OFF | {4'd0, chan};
				evt.second = '0;
				evt.msg_on = present_s1;
			end
			OP_CTRL: begin
				evt.status = STATUS_CTRL | {4'd0, chan};
				evt.second = d2_s1;
				evt.msg_on = 1'b1;
			end
			OP_BEND: begin
				evt.status = STATUS_BEND | {4'd0, chan};
				evt.second = d2_s1;
				evt.msg_on = 1'b1;
			end
			default: begin
				evt.status = '0;
				evt.second = '0;
				evt.msg_on = 1'b0;
			end
		endcase
	end

	mtee_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv_s1),
		.evt       (evt),
		.busy      (ser_busy),
		.done      (ser_done),
		.out_byte  (out_byte),
		.out_track (out_track),
		.out_last  (m_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tdata = {4'd0, out_track, out_byte};

endmodule

@@ tb/tb_midi_track_event_encoder.sv @@
`timescale 1ns / 1ps

module tb_midi_track_event_encoder;
	import mtee_pkg::*;

	// One musical event as offered on the input stream
	typedef struct packed {
		op_t         op;
		logic [31:0] tick;
		logic [3:0]  trk;
		logic        present;
		logic [6:0]  d1;
		logic [6:0]  d2;
	} midi_event_t;

	// One byte of a track stream
	typedef struct packed {
		logic [7:0] data;
		logic [3:0] trk;
		logic       last;
	} stream_byte_t;

	localparam logic [3:0] MASK_ADDR    = {ADDR_MASK, 3'b000};
	localparam logic [3:0] CHANNEL_ADDR = {ADDR_CHANNEL, 3'b000};
	localparam int         SETTLE_CYCLES = 16;
	localparam int         HOLD_CYCLES   = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;   // event_tick, track_index, data_one, data_two, zero
	logic [2:0]  s_axis_tuser = '0;   // operation, note_present
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // out_byte, out_track, zero
	logic        m_axis_tlast;

	// Local copy of the block's registers and per-track tick memory
	logic [15:0] mask_shadow = '0;
	logic [63:0] chan_shadow = '0;
	logic [31:0] last_tick [TRACK_COUNT];
	logic [31:0] gen_tick [TRACK_COUNT];

	midi_event_t  event_q[$];
	stream_byte_t stream_bytes[$];
	midi_event_t  drv_evt;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic src_pause = 1'b0;
	logic hold_arm = 1'b0;
	int   hold_left = 0;

	int err_cnt = 0;
	int events_sent = 0;
	int events_dropped = 0;
	int bytes_checked = 0;
	int settings_used = 0;

	midi_track_event_encoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Work out the bytes an accepted event puts on its track stream
	function automatic void encode_track_event(input midi_event_t ev);
		logic [31:0]  delta;
		logic [31:0]  group;
		logic [3:0]   chan;
		logic [7:0]   status;
		logic [6:0]   second;
		logic         msg_on;
		int           ngrp;
		stream_byte_t sb;
		if (!mask_shadow[ev.trk]) begin
			events_dropped++;
			return;
		end
		delta = ev.tick - last_tick[ev.trk];
		last_tick[ev.trk] = ev.tick;
		chan = chan_shadow[4*ev.trk +: 4];
		case (ev.op)
			OP_NOTE_ON: begin
				status = STATUS_NOTE_ON;
				second = ev.d2;
				msg_on = ev.present;
			end
			OP_NOTE_OFF: begin
				status = STATUS_NOTE_OFF;
				second = '0;
				msg_on = ev.present;
			end
			OP_CTRL: begin
				status = STATUS_CTRL;
				second = ev.d2;
				msg_on = 1'b1;
			end
			default: begin
				status = STATUS_BEND;
				second = ev.d2;
				msg_on = 1'b1;
			end
		endcase
		// Variable-length delta, most significant group first
		ngrp = 1;
		for (int i = 1; i < 5; i++)
			if ((delta >> (7*i)) != 0) ngrp = i + 1;
		for (int i = ngrp - 1; i >= 0; i--) begin
			group = (delta >> (7*i)) & {25'd0, SEVEN_BITS};
			sb.data = {i > 0, group[6:0]};
			sb.trk = ev.trk;
			sb.last = (i == 0) && !msg_on;
			stream_bytes = {stream_bytes, sb};
		end
		if (msg_on) begin
			sb.trk = ev.trk;
			sb.last = 1'b0;
			sb.data = status | {4'd0, chan};
			stream_bytes = {stream_bytes, sb};
			sb.data = {1'b0, ev.d1};
			stream_bytes = {stream_bytes, sb};
			sb.data = {1'b0, second};
			sb.last = 1'b1;
			stream_bytes = {stream_bytes, sb};
		end
	endfunction

	function automatic midi_event_t make_event(input op_t op, input logic [3:0] trk,
		input logic [31:0] tick, input logic present, input logic [6:0] d1,
		input logic [6:0] d2);
		midi_event_t ev;
		ev.op = op;
		ev.trk = trk;
		ev.tick = tick;
		ev.present = present;
		ev.d1 = d1;
		ev.d2 = d2;
		return ev;
	endfunction

	// Random event, mostly on enabled tracks, with deltas of every encoded length
	function automatic midi_event_t random_event();
		midi_event_t ev;
		logic [3:0]  trk;
		logic [31:0] delta;
		trk = 4'($urandom_range(15));
		if (mask_shadow != 0 && $urandom_range(99) < 85)
			while (!mask_shadow[trk]) trk = 4'($urandom_range(15));
		case ($urandom_range(5))
			0: delta = $urandom_range(127);
			1: delta = $urandom_range(16383, 128);
			2: delta = $urandom_range(32'h1F_FFFF, 16384);
			3: delta = $urandom_range(32'h0FFF_FFFF, 32'h20_0000);
			4: delta = $urandom_range(32'hFFFF_FFFF, 32'h1000_0000);
			default: delta = $urandom() - gen_tick[trk];
		endcase
		gen_tick[trk] = gen_tick[trk] + delta;
		ev = make_event(op_t'($urandom_range(3)), trk, gen_tick[trk], 1'($urandom_range(1)),
			7'($urandom_range(127)), 7'($urandom_range(127)));
		return ev;
	endfunction

	task automatic queue_random(input int n);
		repeat (n) event_q = {event_q, random_event()};
	endtask

	task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read(input logic [3:0] addr, output logic [63:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write both registers and read them back; call only while the block is idle
	task automatic set_config(input logic [15:0] mask, input logic [63:0] chan);
		logic [63:0] rd_mask;
		logic [63:0] rd_chan;
		apb_write(MASK_ADDR, {48'd0, mask});
		apb_write(CHANNEL_ADDR, chan);
		mask_shadow = mask;
		chan_shadow = chan;
		settings_used++;
		apb_read(MASK_ADDR, rd_mask);
		apb_read(CHANNEL_ADDR, rd_chan);
		if (rd_mask[15:0] !== mask || rd_chan !== chan) begin
			$display("%0t: register readback expected mask %h chan %h, got mask %h chan %h",
				$time, mask, chan, rd_mask[15:0], rd_chan);
			err_cnt++;
		end
		if (pready !== 1'b1) begin
			$display("%0t: pready expected %b, got %b", $time, 1'b1, pready);
			err_cnt++;
		end
	endtask

	// Wait until every request is taken and every byte has come out
	task automatic drain();
		while (event_q.size() != 0 || s_axis_tvalid || stream_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Drive event requests from the pending queue; predict on acceptance
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			encode_track_event(drv_evt);
			events_sent++;
		end
		if (!s_axis_tvalid || s_axis_tready) begin
			if (arst_n && !src_pause && event_q.size() != 0 &&
				$urandom_range(99) >= send_idle_pct) begin
				drv_evt = event_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {6'd0, drv_evt.d2, drv_evt.d1, drv_evt.trk, drv_evt.tick};
				s_axis_tuser <= {drv_evt.present, drv_evt.op};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Count down a long receiver hold-off
	always @(posedge clk) begin
		if (hold_arm)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// Check output bytes against the oldest prediction; stall at random
	always @(posedge clk) begin
		stream_byte_t exp_b;
		if (m_axis_tvalid && m_axis_tready) begin
			if (stream_bytes.size() == 0) begin
				$display("%0t: unexpected byte %h track %h last %b", $time,
					m_axis_tdata[7:0], m_axis_tdata[11:8], m_axis_tlast);
				err_cnt++;
			end else begin
				exp_b = stream_bytes.pop_front();
				bytes_checked++;
				if (m_axis_tdata[7:0] !== exp_b.data) begin
					$display("%0t: out_byte expected %h, got %h", $time,
						exp_b.data, m_axis_tdata[7:0]);
					err_cnt++;
				end
				if (m_axis_tdata[11:8] !== exp_b.trk) begin
					$display("%0t: out_track expected %h, got %h", $time,
						exp_b.trk, m_axis_tdata[11:8]);
					err_cnt++;
				end
				if (m_axis_tlast !== exp_b.last) begin
					$display("%0t: last_of_event expected %b, got %b", $time,
						exp_b.last, m_axis_tlast);
					err_cnt++;
				end
			end
		end
		m_axis_tready <= arst_n && (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		#2_000_000;
		$display("tb_midi_track_event_encoder failed");
		$finish;
	end

	initial begin
		for (int i = 0; i < TRACK_COUNT; i++) begin
			last_tick[i] = '0;
			gen_tick[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset mask: every event is dropped
		event_q = {event_q, make_event(OP_NOTE_ON, 4'd0, 32'd10, 1'b1, 7'd1, 7'd2)};
		event_q = {event_q, make_event(OP_CTRL, 4'd15, 32'd20, 1'b0, 7'd3, 7'd4)};
		event_q = {event_q, make_event(OP_BEND, 4'd7, 32'hFFFF_FFFF, 1'b1, 7'd127, 7'd127)};
		drain();

		// Directed: all tracks on, distinct channels, every delta length and kind
		set_config(16'hFFFF, 64'hFEDC_BA98_7654_3210);
		event_q = {event_q, make_event(OP_NOTE_ON, 4'd0, 32'd0, 1'b1, 7'd0, 7'd127)};
		event_q = {event_q, make_event(OP_NOTE_ON, 4'd0, 32'd127, 1'b1, 7'd127, 7'd0)};
		event_q = {event_q, make_event(OP_NOTE_OFF, 4'd0, 32'd255, 1'b1, 7'd60, 7'd99)};
		event_q = {event_q, make_event(OP_NOTE_ON, 4'd0, 32'd300, 1'b0, 7'd64, 7'd64)};
		event_q = {event_q, make_event(OP_NOTE_OFF, 4'd0, 32'd300, 1'b0, 7'd64, 7'd64)};
		event_q = {event_q, make_event(OP_CTRL, 4'd1, 32'd16383, 1'b0, 7'd7, 7'd127)};
		event_q = {event_q, make_event(OP_CTRL, 4'd2, 32'd16384, 1'b1, 7'd127, 7'd0)};
		event_q = {event_q, make_event(OP_BEND, 4'd3, 32'h1F_FFFF, 1'b0, 7'd0, 7'd64)};
		event_q = {event_q, make_event(OP_BEND, 4'd4, 32'h20_0000, 1'b1, 7'd127, 7'd127)};
		event_q = {event_q, make_event(OP_NOTE_ON, 4'd5, 32'h0FFF_FFFF, 1'b1, 7'd42, 7'd1)};
		event_q = {event_q, make_event(OP_NOTE_OFF, 4'd6, 32'h1000_0000, 1'b1, 7'd42, 7'd1)};
		event_q = {event_q, make_event(OP_CTRL, 4'd15, 32'hFFFF_FFFF, 1'b1, 7'd1, 7'd2)};
		event_q = {event_q, make_event(OP_BEND, 4'd15, 32'd0, 1'b0, 7'd0, 7'd0)};
		event_q = {event_q, make_event(OP_NOTE_ON, 4'd15, 32'd5, 1'b1, 7'd100, 7'd100)};
		event_q = {event_q, make_event(OP_NOTE_OFF, 4'd15, 32'd3, 1'b1, 7'd100, 7'd0)};
		event_q = {event_q, make_event(OP_NOTE_ON, 4'd14, 32'hAAAA_AAAA, 1'b0, 7'd1, 7'd1)};
		event_q = {event_q, make_event(OP_CTRL, 4'd14, 32'h5555_5555, 1'b1, 7'h55, 7'h2A)};
		event_q = {event_q, make_event(OP_BEND, 4'd9, 32'h8000_0000, 1'b1, 7'h2A, 7'h55)};
		event_q = {event_q, make_event(OP_NOTE_ON, 4'd9, 32'h8000_0000, 1'b1, 7'd0, 7'd0)};
		drain();
		for (int i = 0; i < TRACK_COUNT; i++) gen_tick[i] = last_tick[i];

		// Random, sender idles a little and receiver a lot; one long hold-off
		send_idle_pct = 15;
		recv_idle_pct = 48;
		set_config(16'($urandom()) | 16'h0101, {$urandom(), $urandom()});
		queue_random(120);
		@(posedge clk);
		hold_arm <= 1'b1;
		@(posedge clk);
		hold_arm <= 1'b0;
		drain();

		// Random with only track 0 enabled and the highest channel; sender pauses once
		send_idle_pct = 48;
		recv_idle_pct = 15;
		set_config(16'h0001, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_random(120);
		while (event_q.size() > 60) @(posedge clk);
		src_pause <= 1'b1;
		while (stream_bytes.size() != 0 || s_axis_tvalid) @(posedge clk);
		src_pause <= 1'b0;
		drain();

		// Random with no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(16'($urandom()) | 16'h8000, 64'd0);
		queue_random(120);
		drain();

		$display("Sent %0d events (%0d dropped by the track mask), checked %0d bytes",
			events_sent, events_dropped, bytes_checked);
		$display("over %0d register settings, all kinds and 1 to 5 byte deltas",
			settings_used);
		if (err_cnt == 0)
			$display("tb_midi_track_event_encoder passed");
		else
			$display("tb_midi_track_event_encoder failed");
		$finish;
	end

endmodule
